// ===== rtl/core/dtq_pkg.sv =====
// Package: shared types and constants of the deadline timer queue
`timescale 1ns / 1ps
package dtq_pkg;
  localparam int unsigned SlotsDef    = 32;
  localparam int unsigned RequestsDef = 256;
  localparam int unsigned MaxFired    = 32;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_EXPIRE = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOTIMER = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input item
    logic scan_clr;  // restart minimum scan
    logic scan_step; // examine one slot
    logic do_add;    // write new timer
    logic do_cancel; // mark cancelled timer
    logic do_free;   // free the found minimum
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done; // scan has covered all slots
    logic found;     // a live slot was found
    logic min_del;   // minimum is deleted
    logic min_due;   // minimum is due
    logic min_ntf;   // minimum wants notice
    logic full;      // no free slot
  } dp_sts_t;
endpackage

// ===== rtl/core/dtq_ram.sv =====
// Generic RAM with one write port and one registered read port
`timescale 1ns / 1ps
module dtq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/core/dtq_datapath.sv =====
// Datapath: slot store, handle table and serial minimum scan
`timescale 1ns / 1ps
module dtq_datapath
  import dtq_pkg::*;
#(
  parameter int unsigned Slots    = SlotsDef,
  parameter int unsigned Requests = RequestsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  input  logic [31:0] now_ms_i,
  input  logic [31:0] timeout_ms_i,
  input  logic [7:0]  request_tag_i,
  input  logic        notify_i,
  output logic [7:0]  min_tag_o,
  output logic        tag_ok_o,
  output logic        hnd_hit_o,
  output logic [30:0] wait_o
);
  localparam int unsigned SW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned RW = (Requests > 1) ? $clog2(Requests) : 1;
  localparam int unsigned HW = SW + 1;

  logic [31:0] now_q, tmo_q;
  logic [7:0]  tag_q;
  logic        ntf_q;
  logic [31:0] deadline_q [Slots];
  logic [7:0]  owner_q [Slots];
  logic [Slots-1:0] live_q, del_q, ntf_s_q;
  logic [Requests-1:0] hvalid_q;
  logic [SW-1:0] idx_q, best_q;
  logic [31:0]   bkey_q;
  logic          found_q, done_q;
  logic [SW:0]   cnt_q;
  logic [SW-1:0] hnd_rdata;
  logic [RW-1:0] tag_idx, hnd_waddr, own_idx;
  logic          hnd_we;
  logic [SW-1:0] free_slot;
  logic          have_free;
  logic [31:0]   key, dist_best;

  assign tag_ok_o = ({24'd0, tag_q} < 32'(Requests));
  assign tag_idx  = tag_q[RW-1:0];
  assign own_idx  = owner_q[best_q][RW-1:0];

  // lowest free slot
  always_comb begin
    free_slot = '0;
    have_free = 1'b0;
    for (int s = Slots - 1; s >= 0; s--) begin
      if (!live_q[s]) begin
        free_slot = SW'(s);
        have_free = 1'b1;
      end
    end
  end

  // handle memory write port, written only by add
  always_comb begin
    hnd_we    = cmd_i.do_add && have_free && tag_ok_o;
    hnd_waddr = tag_idx;
  end

  dtq_ram #(.Width(SW), .Depth(Requests)) u_hnd (
    .clk_i  (clk_i),
    .we_i   (hnd_we),
    .waddr_i(hnd_waddr),
    .wdata_i(free_slot),
    .raddr_i(cmd_i.do_free ? own_idx : tag_idx),
    .rdata_o(hnd_rdata)
  );

  logic pend_q;
  logic [RW-1:0] pend_tag_q;
  logic [SW-1:0] pend_slot_q;

  assign hnd_hit_o = hvalid_q[tag_idx] && tag_ok_o;
  assign key = (deadline_q[idx_q] - now_q) ^ 32'h8000_0000;
  assign dist_best = deadline_q[best_q] - now_q;

  // input capture, store updates and scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q      <= '0;
      del_q       <= '0;
      ntf_s_q     <= '0;
      hvalid_q    <= '0;
      idx_q       <= '0;
      best_q      <= '0;
      bkey_q      <= '0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      done_q      <= 1'b0;
      pend_q      <= 1'b0;
      pend_tag_q  <= '0;
      pend_slot_q <= '0;
    end else begin
      // clear handle once the freed owner's entry has been read back
      pend_q <= 1'b0;
      if (pend_q && hvalid_q[pend_tag_q] && hnd_rdata == pend_slot_q) begin
        hvalid_q[pend_tag_q] <= 1'b0;
      end
      if (cmd_i.do_add && have_free) begin
        live_q[free_slot]  <= 1'b1;
        del_q[free_slot]   <= 1'b0;
        ntf_s_q[free_slot] <= ntf_q;
        deadline_q[free_slot] <= now_q + tmo_q;
        owner_q[free_slot] <= tag_q;
        if (tag_ok_o) hvalid_q[tag_idx] <= 1'b1;
      end
      if (cmd_i.do_cancel) begin
        if (32'(hnd_rdata) < 32'(Slots) && live_q[hnd_rdata]) del_q[hnd_rdata] <= 1'b1;
      end
      if (cmd_i.do_free) begin
        live_q[best_q] <= 1'b0;
        del_q[best_q]  <= 1'b0;
        if ({24'd0, owner_q[best_q]} < 32'(Requests)) begin
          pend_q      <= 1'b1;
          pend_tag_q  <= own_idx;
          pend_slot_q <= best_q;
        end
      end
      if (cmd_i.scan_clr) begin
        idx_q   <= '0;
        cnt_q   <= '0;
        found_q <= 1'b0;
        done_q  <= 1'b0;
      end else if (cmd_i.scan_step && !done_q) begin
        if (live_q[idx_q] && (!found_q || key < bkey_q)) begin
          found_q <= 1'b1;
          best_q  <= idx_q;
          bkey_q  <= key;
        end
        if (cnt_q == (HW)'(Slots - 1)) done_q <= 1'b1;
        cnt_q <= cnt_q + 1'b1;
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // capture item fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q <= now_ms_i;
      tmo_q <= timeout_ms_i;
      tag_q <= request_tag_i;
      ntf_q <= notify_i;
    end
  end

  assign sts_o.scan_done = done_q;
  assign sts_o.found     = found_q;
  assign sts_o.min_del   = del_q[best_q];
  assign sts_o.min_due   = (dist_best == 32'd0) || dist_best[31];
  assign sts_o.min_ntf   = ntf_s_q[best_q];
  assign sts_o.full      = !have_free;
  assign min_tag_o = owner_q[best_q];
  assign wait_o    = dist_best[31] ? 31'd0 : dist_best[30:0];
endmodule

// ===== rtl/core/dtq_ctrl.sv =====
// Controller: sequences commands, scans and results
`timescale 1ns / 1ps
module dtq_ctrl
  import dtq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  cmd_i,
  output logic        busy_o,
  output dp_cmd_t     dp_o,
  input  dp_sts_t     sts_i,
  input  logic        tag_ok_i,
  input  logic        hnd_hit_i,
  input  logic [7:0]  min_tag_i,
  input  logic [30:0] wait_i,
  output logic        valid_o,
  output logic        fired_o,
  output logic [7:0]  fired_tag_o,
  output logic [1:0]  status_o,
  output logic        has_timer_o,
  output logic [30:0] next_wait_ms_o,
  output logic        last_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_CMD, S_HND, S_SCANX, S_DECX, S_SCANS, S_DECS, S_GAP
  } state_e;

  state_e state_q;
  logic [1:0] cmd_q;
  status_e status_q;
  logic [5:0] nfired_q;

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    dp_o = '0;
    dp_o.load      = start_i && state_q == S_IDLE;
    dp_o.do_add    = state_q == S_CMD && cmd_q == CMD_ADD;
    dp_o.do_cancel = state_q == S_HND;
    dp_o.scan_step = state_q == S_SCANX || state_q == S_SCANS;
    dp_o.scan_clr  = state_q == S_GAP;
    if (state_q == S_DECX && sts_i.found) begin
      dp_o.do_free = sts_i.min_del ||
        (sts_i.min_due && (!sts_i.min_ntf || nfired_q != 6'(MaxFired)));
    end
    if (state_q == S_DECS && sts_i.found && sts_i.min_del) dp_o.do_free = 1'b1;
  end

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      valid_o        <= 1'b0;
      last_o         <= 1'b0;
      fired_o        <= 1'b0;
      fired_tag_o    <= '0;
      status_o       <= ST_OK;
      has_timer_o    <= 1'b0;
      next_wait_ms_o <= '0;
      nfired_q       <= '0;
      cmd_q          <= '0;
      status_q       <= ST_OK;
    end else begin
      valid_o <= 1'b0;
      last_o  <= 1'b0;
      fired_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            cmd_q    <= cmd_i;
            nfired_q <= '0;
            status_q <= ST_OK;
            state_q  <= S_CMD;
          end
        end
        S_CMD: begin
          if (cmd_q == CMD_ADD && sts_i.full) status_q <= ST_FULL;
          if (cmd_q == CMD_CANCEL) begin
            if (!(tag_ok_i && hnd_hit_i)) begin
              status_q <= ST_NOTIMER;
              state_q  <= S_GAP;
            end else begin
              state_q <= S_HND;
            end
          end else begin
            state_q <= S_GAP;
          end
        end
        S_HND: state_q <= S_GAP;
        S_SCANX, S_SCANS: begin
          if (sts_i.scan_done) state_q <= (state_q == S_SCANX) ? S_DECX : S_DECS;
        end
        S_DECX: begin
          if (!sts_i.found) state_q <= S_GAP;
          else if (sts_i.min_del) state_q <= S_GAP;
          else if (!sts_i.min_due) state_q <= S_GAP;
          else if (sts_i.min_ntf && nfired_q == 6'(MaxFired)) state_q <= S_GAP;
          else begin
            if (sts_i.min_ntf) begin
              valid_o     <= 1'b1;
              fired_o     <= 1'b1;
              fired_tag_o <= min_tag_i;
              status_o    <= ST_OK;
              has_timer_o <= 1'b0;
              next_wait_ms_o <= '0;
              nfired_q    <= nfired_q + 1'b1;
            end
            state_q <= S_GAP;
          end
          if (!(sts_i.found && (sts_i.min_del || (sts_i.min_due &&
              (!sts_i.min_ntf || nfired_q != 6'(MaxFired)))))) begin
            cmd_q <= CMD_QUERY;
          end
        end
        S_DECS: begin
          if (sts_i.found && sts_i.min_del) begin
            state_q <= S_GAP;
          end else begin
            valid_o     <= 1'b1;
            last_o      <= 1'b1;
            fired_tag_o <= '0;
            status_o    <= status_q;
            has_timer_o <= sts_i.found;
            next_wait_ms_o <= sts_i.found ? wait_i : 31'd0;
            state_q     <= S_IDLE;
          end
        end
        S_GAP: begin
          // expire keeps scanning until it stops, then summary scans
          state_q <= (cmd_q == CMD_EXPIRE) ? S_SCANX : S_SCANS;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  ap_fire_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nfired_q <= 6'(MaxFired)) else $error("fired count overrun");
  ap_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> state_q == S_IDLE) else $error("summary not final");
  ap_free_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_o.do_free |=> !dp_o.do_free) else $error("double free");
endmodule

// ===== rtl/core/deadline_timer_queue_top.sv =====
// Top level of the deadline timer queue
//  channel | handshake          | fields
//  command | start / busy        | cmd, now_ms, timeout_ms, request_tag, notify
//  result  | result_valid_o     | fired, fired_tag, status, has_timer, next_wait_ms, last
// A minimum scan restarts, examines one slot a cycle, settles and decides; an item takes
// its command step (plus a handle step for a cancel that hits) and one scan per decision.
// Every deleted timer dropped and every expired timer adds a scan; expire needs at most
// Slots+2 scans.
// Reset clears occupancy and handle valid bits at once; no clearing pass.
// Results show for one cycle each; the receiver cannot stall.
`timescale 1ns / 1ps
module deadline_timer_queue_top
  import dtq_pkg::*;
#(
  parameter int unsigned Slots    = SlotsDef,
  parameter int unsigned Requests = RequestsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] now_ms_i,
  input  logic [31:0] timeout_ms_i,
  input  logic [7:0]  request_tag_i,
  input  logic        notify_i,
  output logic        result_valid_o,
  output logic        fired_o,
  output logic [7:0]  fired_tag_o,
  output logic [1:0]  status_o,
  output logic        has_timer_o,
  output logic [30:0] next_wait_ms_o,
  output logic        last_o
);
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  logic [7:0]  min_tag;
  logic        tag_ok, hnd_hit;
  logic [30:0] wait_ms;

  dtq_datapath #(.Slots(Slots), .Requests(Requests)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(dp_cmd), .sts_o(dp_sts),
    .now_ms_i(now_ms_i), .timeout_ms_i(timeout_ms_i),
    .request_tag_i(request_tag_i), .notify_i(notify_i),
    .min_tag_o(min_tag), .tag_ok_o(tag_ok), .hnd_hit_o(hnd_hit), .wait_o(wait_ms)
  );

  dtq_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .cmd_i(cmd_i), .busy_o(busy),
    .dp_o(dp_cmd), .sts_i(dp_sts), .tag_ok_i(tag_ok), .hnd_hit_i(hnd_hit),
    .min_tag_i(min_tag), .wait_i(wait_ms), .valid_o(result_valid_o),
    .fired_o(fired_o), .fired_tag_o(fired_tag_o), .status_o(status_o),
    .has_timer_o(has_timer_o), .next_wait_ms_o(next_wait_ms_o), .last_o(last_o)
  );
endmodule

// ===== test/tb_top.sv =====
// Testbench for the deadline timer queue: self-checking, random and directed items
`timescale 1ns / 1ps

// Expected-result store with its own copy of the timer state
class timer_scoreboard;
  typedef struct packed {
    logic        fired;
    logic [7:0]  tag;
    logic [1:0]  status;
    logic        has;
    logic [30:0] wait_ms;
    logic        last;
  } outcome_t;

  logic [31:0] deadline [32];
  logic [7:0]  owner [32];
  bit          live [32];
  bit          deleted [32];
  bit          ntf [32];
  logic [4:0]  handle [256];
  bit          handle_ok [256];
  outcome_t    pending [$];
  int          errors;

  function new();
    errors = 0;
    for (int s = 0; s < 32; s++) begin
      live[s] = 0;
      deleted[s] = 0;
    end
    for (int r = 0; r < 256; r++) handle_ok[r] = 0;
  endfunction

  function int earliest(logic [31:0] now);
    int best;
    logic [31:0] bk, k;
    best = -1;
    bk = '0;
    for (int s = 0; s < 32; s++) begin
      if (live[s]) begin
        k = (deadline[s] - now) ^ 32'h8000_0000;
        if (best < 0 || k < bk) begin
          best = s;
          bk = k;
        end
      end
    end
    return best;
  endfunction

  function void release_slot(int s);
    live[s] = 0;
    deleted[s] = 0;
    if (handle_ok[owner[s]] && handle[owner[s]] == s) handle_ok[owner[s]] = 0;
  endfunction

  // Note an accepted item and queue the results it causes
  function void note_item(dtq_pkg::cmd_e c, logic [31:0] now, logic [31:0] tmo,
                          logic [7:0] tag, logic nt);
    int f, s, n;
    logic [31:0] d;
    dtq_pkg::status_e st;
    outcome_t o;
    st = dtq_pkg::ST_OK;
    n = 0;
    if (c == dtq_pkg::CMD_ADD) begin
      f = -1;
      for (int i = 31; i >= 0; i--) if (!live[i]) f = i;
      if (f < 0) st = dtq_pkg::ST_FULL;
      else begin
        deadline[f] = now + tmo;
        owner[f] = tag;
        ntf[f] = nt;
        live[f] = 1;
        deleted[f] = 0;
        handle[tag] = 5'(f);
        handle_ok[tag] = 1;
      end
    end else if (c == dtq_pkg::CMD_CANCEL) begin
      if (handle_ok[tag]) begin
        if (live[handle[tag]]) deleted[handle[tag]] = 1;
      end else st = dtq_pkg::ST_NOTIMER;
    end else if (c == dtq_pkg::CMD_EXPIRE) begin
      forever begin
        s = earliest(now);
        if (s < 0) break;
        if (deleted[s]) begin
          release_slot(s);
          continue;
        end
        d = deadline[s] - now;
        if (d != 0 && !d[31]) break;
        if (ntf[s]) begin
          if (n >= dtq_pkg::MaxFired) break;
          o = '{1'b1, owner[s], 2'd0, 1'b0, 31'd0, 1'b0};
          pending.push_back(o);
          n++;
        end
        release_slot(s);
      end
    end
    // Drop deleted timers at the front, then report the earliest live one
    o = '{1'b0, 8'd0, st, 1'b0, 31'd0, 1'b1};
    forever begin
      s = earliest(now);
      if (s < 0) break;
      if (deleted[s]) begin
        release_slot(s);
        continue;
      end
      d = deadline[s] - now;
      o.has = 1;
      o.wait_ms = d[31] ? 31'd0 : d[30:0];
      break;
    end
    pending.push_back(o);
  endfunction

  // Compare one result with the oldest expectation
  function void check_result(outcome_t a);
    outcome_t e;
    if (pending.size() == 0) begin
      $error("unexpected result %p", a);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (a.fired !== e.fired) begin
      $error("fired: expected %0d actual %0d", e.fired, a.fired); errors++;
    end
    if (a.tag !== e.tag) begin
      $error("fired_tag: expected %0d actual %0d", e.tag, a.tag); errors++;
    end
    if (a.status !== e.status) begin
      $error("status: expected %0d actual %0d", e.status, a.status); errors++;
    end
    if (a.has !== e.has) begin
      $error("has_timer: expected %0d actual %0d", e.has, a.has); errors++;
    end
    if (a.wait_ms !== e.wait_ms) begin
      $error("next_wait_ms: expected %0d actual %0d", e.wait_ms, a.wait_ms); errors++;
    end
    if (a.last !== e.last) begin
      $error("last: expected %0d actual %0d", e.last, a.last); errors++;
    end
  endfunction
endclass

module tb_top;
  import dtq_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  cmd_i = '0;
  logic [31:0] now_ms_i = '0;
  logic [31:0] timeout_ms_i = '0;
  logic [7:0]  request_tag_i = '0;
  logic        notify_i = 0;
  logic        result_valid_o, fired_o, has_timer_o, last_o;
  logic [7:0]  fired_tag_o;
  logic [1:0]  status_o;
  logic [30:0] next_wait_ms_o;

  timer_scoreboard board = new();
  logic [31:0] clock_ms = 32'hFFFF_FF00;
  int unsigned cycles = 0;
  bit          calm = 0;

  always #1 clk_i = ~clk_i;

  deadline_timer_queue_top u_dut (.*);

  // Check every result strobe
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && result_valid_o)
      board.check_result('{fired_o, fired_tag_o, status_o, has_timer_o,
                           next_wait_ms_o, last_o});
  end

  // Abort on a hung run
  initial begin
    wait (cycles > 2_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  // Issue one command, wait until the queue is no longer busy, then drop start
  task automatic issue(cmd_e c, logic [31:0] now, logic [31:0] tmo,
                       logic [7:0] tag, logic nt);
    if (!calm) while ($urandom_range(99) < 32) @(posedge clk_i);
    start <= 1;
    cmd_i <= c;
    now_ms_i <= now;
    timeout_ms_i <= tmo;
    request_tag_i <= tag;
    notify_i <= nt;
    do @(posedge clk_i); while (busy);
    board.note_item(c, now, tmo, tag, nt);
    start <= 0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    int r;
    logic [31:0] tmo;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: extremes, every command, full store, wrap, stale handles
    issue(CMD_QUERY, 32'd0, 32'd0, 8'd0, 1'b0);
    issue(CMD_CANCEL, 32'd0, 32'd0, 8'd255, 1'b0);
    issue(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 1'b1);
    issue(CMD_ADD, 32'hFFFF_FFFF, 32'd0, 8'd0, 1'b1);
    issue(CMD_ADD, 32'd5, 32'h7FFF_FFFF, 8'd3, 1'b0);
    issue(CMD_ADD, 32'd5, 32'h8000_0000, 8'd3, 1'b1);
    issue(CMD_CANCEL, 32'd6, 32'd0, 8'd3, 1'b0);
    issue(CMD_CANCEL, 32'd6, 32'd0, 8'd3, 1'b0);
    issue(CMD_EXPIRE, 32'd10, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    for (int i = 0; i < 33; i++)
      issue(CMD_ADD, 32'd100, 32'(i % 4), 8'(i), 1'b1);
    issue(CMD_EXPIRE, 32'd200, 32'd0, 8'd0, 1'b0);
    issue(CMD_EXPIRE, 32'd200, 32'd0, 8'd0, 1'b0);
    issue(CMD_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    // Hold off until every expected result is in
    drain();

    // Random: mostly add/cancel/expire on a moving clock
    for (int i = 0; i < 385; i++) begin
      calm = (i >= 150 && i < 230);
      clock_ms = clock_ms + $urandom_range(40);
      r = $urandom_range(99);
      tmo = ($urandom_range(9) == 0) ? $urandom : $urandom_range(300);
      if (r < 45)
        issue(CMD_ADD, clock_ms, tmo, 8'($urandom_range(40)), $urandom_range(3) != 0);
      else if (r < 65)
        issue(CMD_CANCEL, clock_ms, $urandom, 8'($urandom_range(45)), 1'($urandom));
      else if (r < 93)
        issue(CMD_EXPIRE, clock_ms, $urandom, 8'($urandom), 1'($urandom));
      else if (r < 96)
        issue(CMD_QUERY, clock_ms, $urandom, 8'($urandom), 1'($urandom));
      else
        issue(cmd_e'($urandom_range(3)), $urandom, $urandom, 8'($urandom),
              1'($urandom));
    end

    drain();
    if (board.errors == 0 && board.pending.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
